/* sv/bdr_pkg.sv */
`default_nettype none
package bdr_pkg;

  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int HALF_W    = DIM_W - 1;
  localparam int COEF_W    = 18;
  localparam int FRAC      = 16;
  localparam int SUM_W     = 2 * DIM_W;
  localparam int ROOT_W    = 29;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int INDEX_W   = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [INDEX_W-1:0] src_index;
    logic               in_range;
  } rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } cfg_t;

  // offsets from frame center, carried alongside the radius
  typedef struct packed {
    logic signed [DIM_W-1:0] dx;
    logic signed [DIM_W-1:0] dy;
  } side_t;

  // source coordinate before index formation
  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] sx;
    logic [DIM_W-1:0] sy;
  } coord_t;

  function automatic logic [HALF_W-1:0] half_dim(input logic [DIM_W-1:0] d);
    return d[DIM_W-1:1];
  endfunction

endpackage
`default_nettype wire

/* sv/barrel_distortion_remap.sv */
// Radial barrel distortion remap: output pixel coordinate in, source
// coordinate to fetch out, one request per clock.
// Input channel in_valid / in_stall / in_data carries (out_x, out_y);
// output channel out_valid / out_stall / out_data carries src_x, src_y,
// src_index and in_range. Out-of-frame sources come back with in_range low
// and all other fields zero.
// Configuration: cfg_we with cfg_index 0..4 writes image_width,
// image_height, coef_a, coef_b, coef_c (Q2.16). Write only while no
// request is in flight.
// The pipeline holds one front stage, 29 square-root stages and 29
// divide stages (one result bit each), ten polynomial and scaling stages
// and the output register. Throughput is one request per cycle.
// When the output is stalled while holding a result, the whole pipeline
// holds and in_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads width 640, height 480
// and zero coefficients.
`default_nettype none
module barrel_distortion_remap import bdr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rsp_t                 out_data
);

  cfg_t cfg;
  logic en;

  logic [HALF_W-1:0] hw;
  logic [HALF_W-1:0] hh;
  logic [HALF_W-1:0] hw_div;
  logic signed [DIM_W-1:0] dx, dy;
  logic signed [SUM_W-1:0] sqx, sqy;

  logic f_valid;
  logic [SUM_W-1:0] f_sum;
  side_t f_side;

  logic sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t sq_side;

  logic dv_valid;
  logic [ROOT_W-1:0] dv_quot;
  side_t dv_side;

  logic pl_valid;
  coord_t pl_coord;

  logic [SUM_W-1:0] yw;
  logic [SUM_W:0] idx;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= 13'd640;
      cfg.image_height <= 13'd480;
      cfg.coef_a       <= '0;
      cfg.coef_b       <= '0;
      cfg.coef_c       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  cfg.image_width  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: cfg.image_height <= cfg_data[DIM_W-1:0];
        CFG_COEF_A: cfg.coef_a       <= cfg_data;
        CFG_COEF_B: cfg.coef_b       <= cfg_data;
        CFG_COEF_C: cfg.coef_c       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hw     = half_dim(cfg.image_width);
  assign hh     = half_dim(cfg.image_height);
  assign hw_div = (hw == '0) ? HALF_W'(1) : hw;

  always_comb begin
    dx  = $signed({1'b0, in_data.out_x}) - $signed({1'b0, hw});
    dy  = $signed({1'b0, in_data.out_y}) - $signed({1'b0, hh});
    sqx = dx * dx;
    sqy = dy * dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_sum     <= sqx + sqy;
      f_side.dx <= dx;
      f_side.dy <= dy;
    end
  end

  bdr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_sum    (f_sum),
    .in_side   (f_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  bdr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .divisor   (hw_div),
    .in_valid  (sq_valid),
    .in_num    (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  bdr_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (dv_valid),
    .in_rad    (dv_quot),
    .in_side   (dv_side),
    .out_valid (pl_valid),
    .out_coord (pl_coord)
  );

  assign yw  = pl_coord.sy * cfg.image_width;
  assign idx = {{(SUM_W + 1 - DIM_W){1'b0}}, pl_coord.sx} + {1'b0, yw};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.in_range  <= pl_coord.ok;
      out_data.src_x     <= pl_coord.ok ? pl_coord.sx[COORD_W-1:0] : '0;
      out_data.src_y     <= pl_coord.ok ? pl_coord.sy[COORD_W-1:0] : '0;
      out_data.src_index <= pl_coord.ok ? idx[INDEX_W-1:0] : '0;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.in_range |->
      out_data.src_x == '0 && out_data.src_y == '0 && out_data.src_index == '0)
    else $error("out-of-range result carries nonzero fields");

  a_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.in_range |->
      {1'b0, out_data.src_x} < cfg.image_width &&
      {1'b0, out_data.src_y} < cfg.image_height)
    else $error("in-range result lies outside the frame");

endmodule
`default_nettype wire

/* sv/bdr_sqrt.sv */
`default_nettype none
module bdr_sqrt import bdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  // floor(sqrt(sum * 2^32)), one root bit per stage
  logic              valid_q [ROOT_W];
  logic [ROOT_W-1:0] root_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q   [ROOT_W];
  logic [RAD_W-1:0]  rad_q   [ROOT_W];
  side_t             side_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [RAD_W-1:0]  rad_in;
    side_t             side_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fit;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = {in_sum, {(RAD_W - SUM_W){1'b0}}};
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_in[ROOT_W-2:0], fit};
        rem_q[k]  <= fit ? rem_sh - trial : rem_sh;
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = valid_q[ROOT_W-1];
  assign out_root  = root_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];

endmodule
`default_nettype wire

/* sv/bdr_div.sv */
`default_nettype none
module bdr_div import bdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [HALF_W-1:0] divisor,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_num,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_quot,
  output side_t             out_side
);

  // restoring divide, one quotient bit per stage
  logic              valid_q [ROOT_W];
  logic [ROOT_W-1:0] num_q   [ROOT_W];
  logic [ROOT_W-1:0] quot_q  [ROOT_W];
  logic [HALF_W-1:0] rem_q   [ROOT_W];
  side_t             side_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [ROOT_W-1:0] num_in;
    logic [ROOT_W-1:0] quot_in;
    logic [HALF_W-1:0] rem_in;
    side_t             side_in;
    logic [HALF_W:0]   rem_sh;
    logic [HALF_W:0]   rem_dn;
    logic              fit;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign num_in  = in_num;
      assign quot_in = '0;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign num_in  = num_q[k-1];
      assign quot_in = quot_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_sh = {rem_in, num_in[ROOT_W-1]};
    assign fit    = rem_sh >= {1'b0, divisor};
    assign rem_dn = fit ? rem_sh - {1'b0, divisor} : rem_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_q[k]  <= {num_in[ROOT_W-2:0], 1'b0};
        quot_q[k] <= {quot_in[ROOT_W-2:0], fit};
        rem_q[k]  <= rem_dn[HALF_W-1:0];
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = valid_q[ROOT_W-1];
  assign out_quot  = quot_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];

endmodule
`default_nettype wire

/* sv/bdr_poly.sv */
`default_nettype none
module bdr_poly import bdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_rad,
  input  side_t             in_side,
  output logic              out_valid,
  output coord_t            out_coord
);

  localparam logic [61:0] SAT_MAG = {1'b1, 61'b0};

  logic [HALF_W-1:0] hw;
  logic [HALF_W-1:0] hh;

  // valid per stage
  logic [9:0] vld;

  // stage registers
  logic [46:0] p1_m;
  logic p1_neg;
  logic [ROOT_W-1:0] p1_r, p2_r, p3_r, p4_r;
  side_t p1_side, p2_side, p3_side, p4_side, p5_side, p6_side, p7_side;
  logic signed [32:0] p2_acc;
  logic [60:0] p3_m;
  logic p3_neg;
  logic signed [46:0] p4_acc;
  logic [51:0] p5_lo, p5_hi;
  logic p5_neg;
  logic [61:0] p6_m;
  logic p6_neg;
  logic [61:0] p7_mag;
  logic p7_neg;
  logic [42:0] p8_xlo, p8_xhi, p8_ylo, p8_yhi;
  logic p8_xneg, p8_yneg;
  logic [61:0] p9_mx, p9_my;
  logic p9_xneg, p9_yneg;
  coord_t p10;

  // combinational per stage
  logic [COEF_W-1:0] abs_a;
  logic [30:0] t1;
  logic signed [32:0] acc1;
  logic signed [32:0] abs1;
  logic [60:0] m2;
  logic [44:0] t2;
  logic signed [46:0] acc2;
  logic signed [46:0] abs2;
  logic [45:0] abs2u;
  logic [74:0] prod3;
  logic [61:0] m3;
  logic signed [20:0] dval;
  logic signed [63:0] fs;
  logic signed [63:0] fabs;
  logic [61:0] fmag;
  logic signed [DIM_W-1:0] adx, ady;
  logic [73:0] prodx, prody;
  logic signed [63:0] sumx, sumy;
  logic [46:0] sxv, syv;
  logic okx, oky;

  assign hw = half_dim(cfg.image_width);
  assign hh = half_dim(cfg.image_height);

  always_comb begin
    abs_a = cfg.coef_a[COEF_W-1] ? COEF_W'(-cfg.coef_a) : COEF_W'(cfg.coef_a);

    t1   = p1_m[46:16];
    acc1 = (p1_neg ? -$signed({2'b00, t1}) : $signed({2'b00, t1}))
         + $signed({{15{cfg.coef_b[COEF_W-1]}}, cfg.coef_b});

    abs1 = p2_acc[32] ? -p2_acc : p2_acc;
    m2   = abs1[31:0] * p2_r;

    t2   = p3_m[60:16];
    acc2 = (p3_neg ? -$signed({2'b00, t2}) : $signed({2'b00, t2}))
         + $signed({{29{cfg.coef_c[COEF_W-1]}}, cfg.coef_c});

    abs2  = p4_acc[46] ? -p4_acc : p4_acc;
    abs2u = abs2[45:0];

    prod3 = {23'b0, p5_lo} + {p5_hi, 23'b0};
    m3    = (|prod3[74:64]) ? SAT_MAG : {14'b0, prod3[63:16]};

    dval = 21'sd65536
         - $signed({{3{cfg.coef_a[COEF_W-1]}}, cfg.coef_a})
         - $signed({{3{cfg.coef_b[COEF_W-1]}}, cfg.coef_b})
         - $signed({{3{cfg.coef_c[COEF_W-1]}}, cfg.coef_c});
    fs   = (p6_neg ? -$signed({2'b00, p6_m}) : $signed({2'b00, p6_m}))
         + $signed({{43{dval[20]}}, dval});
    fabs = fs[63] ? -fs : fs;
    fmag = (fabs > $signed({2'b00, SAT_MAG})) ? SAT_MAG : fabs[61:0];

    adx = p7_side.dx[DIM_W-1] ? -p7_side.dx : p7_side.dx;
    ady = p7_side.dy[DIM_W-1] ? -p7_side.dy : p7_side.dy;

    prodx = {31'b0, p8_xlo} + {p8_xhi, 31'b0};
    prody = {31'b0, p8_ylo} + {p8_yhi, 31'b0};

    sumx = (p9_xneg ? -$signed({2'b00, p9_mx}) : $signed({2'b00, p9_mx}))
         + $signed({36'b0, hw, 16'b0});
    sumy = (p9_yneg ? -$signed({2'b00, p9_my}) : $signed({2'b00, p9_my}))
         + $signed({36'b0, hh, 16'b0});
    sxv  = sumx[63] ? '0 : sumx[62:16];
    syv  = sumy[63] ? '0 : sumy[62:16];
    okx  = (sumx > -64'sd65536) && (sxv < {34'b0, cfg.image_width});
    oky  = (sumy > -64'sd65536) && (syv < {34'b0, cfg.image_height});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_m    <= abs_a * in_rad;
      p1_neg  <= cfg.coef_a[COEF_W-1];
      p1_r    <= in_rad;
      p1_side <= in_side;

      p2_acc  <= acc1;
      p2_r    <= p1_r;
      p2_side <= p1_side;

      p3_m    <= m2;
      p3_neg  <= p2_acc[32];
      p3_r    <= p2_r;
      p3_side <= p2_side;

      p4_acc  <= acc2;
      p4_r    <= p3_r;
      p4_side <= p3_side;

      p5_lo   <= abs2u[22:0] * p4_r;
      p5_hi   <= abs2u[45:23] * p4_r;
      p5_neg  <= p4_acc[46];
      p5_side <= p4_side;

      p6_m    <= m3;
      p6_neg  <= p5_neg;
      p6_side <= p5_side;

      p7_mag  <= fmag;
      p7_neg  <= fs[63];
      p7_side <= p6_side;

      p8_xlo  <= adx[11:0] * p7_mag[30:0];
      p8_xhi  <= adx[11:0] * p7_mag[61:31];
      p8_ylo  <= ady[11:0] * p7_mag[30:0];
      p8_yhi  <= ady[11:0] * p7_mag[61:31];
      p8_xneg <= p7_side.dx[DIM_W-1] ^ p7_neg;
      p8_yneg <= p7_side.dy[DIM_W-1] ^ p7_neg;

      p9_mx   <= (|prodx[73:48]) ? SAT_MAG : {14'b0, prodx[47:0]};
      p9_my   <= (|prody[73:48]) ? SAT_MAG : {14'b0, prody[47:0]};
      p9_xneg <= p8_xneg;
      p9_yneg <= p8_yneg;

      p10.ok  <= okx && oky;
      p10.sx  <= sxv[DIM_W-1:0];
      p10.sy  <= syv[DIM_W-1:0];
    end
  end

  assign out_valid = vld[9];
  assign out_coord = p10;

endmodule
`default_nettype wire

/* bench/barrel_distortion_remap_tb.sv */
`timescale 1ns / 1ps
module barrel_distortion_remap_tb;
  import bdr_pkg::*;

  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam longint SAT = 64'sd1 <<< 61;
  localparam int LIMIT = 400000;
  localparam int LATENCY = 70;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  barrel_distortion_remap DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // remap settings mirrored for prediction
  logic [DIM_W-1:0] img_w, img_h;
  longint coef_a, coef_b, coef_c;

  rsp_t src_expected[$];
  int errors = 0;
  int cycles = 0;
  int requests = 0;
  int hits = 0;
  bit idling = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic longint sat(input longint v);
    if (v > SAT) return SAT;
    if (v < -SAT) return -SAT;
    return v;
  endfunction

  function automatic longint fx_mul(input longint p, input longint q);
    bit [127:0] mp, mq, prod;
    longint m;
    mp = p < 0 ? 128'(-p) : 128'(p);
    mq = q < 0 ? 128'(-q) : 128'(q);
    prod = mp * mq;
    if (prod[127:64] != 0) m = SAT;
    else begin
      m = longint'(prod[63:0] >> FRAC);
      if (prod[63:0] >> FRAC > 64'(SAT)) m = SAT;
    end
    return ((p < 0) != (q < 0)) ? -m : m;
  endfunction

  function automatic longint fx_add(input longint p, input longint q);
    return sat(sat(p) + sat(q));
  endfunction

  function automatic longint fx_trunc(input longint v);
    longint m;
    m = (v < 0 ? -v : v) >>> FRAC;
    return v < 0 ? -m : m;
  endfunction

  function automatic bit [63:0] int_sqrt(input bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic rsp_t source_of(input req_t q);
    rsp_t o;
    longint hw, hh, dx, dy, r, d, acc, sx, sy;
    bit [63:0] root, dv;
    hw = longint'(img_w >> 1);
    hh = longint'(img_h >> 1);
    dx = longint'(q.out_x) - hw;
    dy = longint'(q.out_y) - hh;
    root = int_sqrt(64'(dx * dx + dy * dy) << 32);
    dv = 64'(hw > 0 ? hw : 1) << 16;
    r = longint'((root << FRAC) / dv);
    d = ONE - coef_a - coef_b - coef_c;
    acc = fx_add(fx_mul(coef_a, r), coef_b);
    acc = fx_add(fx_mul(acc, r), coef_c);
    acc = fx_add(fx_mul(acc, r), d);
    sx = fx_trunc(fx_add(fx_mul(dx * ONE, acc), hw * ONE));
    sy = fx_trunc(fx_add(fx_mul(dy * ONE, acc), hh * ONE));
    o = '0;
    if (sx >= 0 && sx < longint'(img_w) && sy >= 0 && sy < longint'(img_h)) begin
      o.src_x = sx[COORD_W-1:0];
      o.src_y = sy[COORD_W-1:0];
      o.src_index = 24'(sx + sy * longint'(img_w));
      o.in_range = 1'b1;
    end
    return o;
  endfunction

  // response checker
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (src_expected.size() == 0) report("response with no request outstanding");
      else begin
        e = src_expected.pop_front();
        if (out_data.in_range !== e.in_range)
          report($sformatf("in_range %0b exp %0b", out_data.in_range, e.in_range));
        if (out_data.src_x !== e.src_x)
          report($sformatf("src_x %0d exp %0d", out_data.src_x, e.src_x));
        if (out_data.src_y !== e.src_y)
          report($sformatf("src_y %0d exp %0d", out_data.src_y, e.src_y));
        if (out_data.src_index !== e.src_index)
          report($sformatf("src_index %0d exp %0d", out_data.src_index, e.src_index));
        hits += e.in_range;
      end
    end
  end

  // output backpressure
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    req_t q;
    q.out_x = x;
    q.out_y = y;
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (in_stall);
    src_expected.push_back(source_of(q));
    requests++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (src_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_WIDTH: img_w = v[DIM_W-1:0];
      CFG_HEIGHT: img_h = v[DIM_W-1:0];
      CFG_COEF_A: coef_a = longint'($signed(v));
      CFG_COEF_B: coef_b = longint'($signed(v));
      CFG_COEF_C: coef_c = longint'($signed(v));
      default: ;
    endcase
  endtask

  task automatic configure(input int w, input int h, input int a, input int b, input int c);
    drain();
    repeat (LATENCY) @(posedge clk);
    write_reg(CFG_WIDTH, {5'($urandom), 13'(w)});
    write_reg(CFG_HEIGHT, {5'($urandom), 13'(h)});
    write_reg(CFG_COEF_A, 18'(a));
    write_reg(CFG_COEF_B, 18'(b));
    write_reg(CFG_COEF_C, 18'(c));
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults;
    send(0, 0);
    send(320, 240);
    send(639, 479);
    send(4095, 4095);
    send(640, 0);
  endtask

  task automatic test_directed;
    configure(640, 480, 131071, -131072, 131071);
    send(0, 0);
    send(320, 240);
    send(4095, 0);
    configure(640, 480, -3000, 2000, -1000);
    send(0, 0);
    send(639, 479);
    send(100, 400);
    configure(1, 1, 500, 0, 0);
    send(0, 0);
    send(5, 7);
    configure(0, 0, 0, 0, 0);
    send(0, 0);
    send(1, 0);
    configure(8191, 8191, 0, 0, 0);
    send(4095, 4095);
    send(0, 4095);
    send(4095, 0);
    configure(4096, 4096, -131072, -131072, -131072);
    send(0, 0);
    send(2048, 2048);
    send(4095, 17);
    configure(2, 1, 0, 0, -65536);
    send(0, 0);
    send(1, 0);
  endtask

  task automatic test_random(input int n);
    int w, h, a, b, c, span;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 9))
          0: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
          1: begin w = 4096; h = $urandom_range(1, 4096); end
          2: begin w = $urandom_range(0, 3); h = $urandom_range(1, 3); end
          default: begin w = $urandom_range(2, 1024); h = $urandom_range(1, 1024); end
        endcase
        span = ($urandom_range(0, 4) == 0) ? 131071 : 12000;
        a = $urandom_range(0, 2 * span) - span;
        b = $urandom_range(0, 2 * span) - span;
        c = $urandom_range(0, 2 * span) - span;
        configure(w, h, a, b, c);
      end
      if ($urandom_range(0, 9) == 0 || w < 2 || h < 1)
        send(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
      else
        send(COORD_W'($urandom_range(0, w > 4096 ? 4095 : w - 1)),
             COORD_W'($urandom_range(0, h > 4096 ? 4095 : h - 1)));
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    img_w = 640;
    img_h = 480;
    coef_a = 0;
    coef_b = 0;
    coef_c = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    idling = 1'b1;
    test_directed();
    test_random(1350);
    idling = 1'b0;
    test_random(300);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("remapped %0d pixel requests across random frame sizes and coefficients,",
      requests);
    $display("%0d landed inside the frame; %0d mismatches", hits, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
